// File: hdl/sfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame parser package
// Shared types, register map and framing constants.
// ----------------------------------------------------------------------------
package sfp_pkg;

  // Framing constants
  localparam logic [7:0] FRAME_LEN_BYTE = 8'd14;
  localparam int         PAYLOAD_BYTES  = 13;
  localparam int         CNT_W          = $clog2(PAYLOAD_BYTES + 1);
  localparam int         IDX_W          = $clog2(PAYLOAD_BYTES);

  // Register reset values
  localparam logic [7:0] START_MARKER_RST = 8'h5A;
  localparam logic [7:0] COMMAND_CODE_RST = 8'hA1;

  // Register map: index is the word address
  localparam int          PADDR_W = 3;
  localparam logic [0:0] REG_START_MARKER = 1'b0;
  localparam logic [0:0] REG_COMMAND_CODE = 1'b1;

  // Parser phases; codes 5..7 behave as hunting
  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_LEN   = 3'd1,
    PH_CMD   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHECK = 3'd4
  } phase_t;

  // Configuration seen by the parser
  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] command_code;
  } sfp_cfg_t;

  // One decoded frame
  typedef struct packed {
    logic [31:0] heart_word;
    logic [31:0] breath_word;
    logic [31:0] distance_word;
    logic [7:0]  flag_byte;
  } frame_t;

endpackage

// File: hdl/sensor_frame_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame parser top level
// Byte-stream frame parser with XOR check and APB-style configuration.
// ----------------------------------------------------------------------------
// Takes one link byte per word, one word per clock cycle. A frame is the
// start marker, a length byte of 14, the command byte, 13 payload bytes and
// a check byte equal to the XOR of length, command and payload. A good frame
// produces one result word in the cycle after its check byte: three big-endian
// 32-bit words and a flag byte. Bad frames are dropped without a result.
// The result sits in an output register; input words keep flowing while it
// waits, and only a check byte stalls, when the previous result is still
// not taken. Start marker (address 0) and command code (address 4) are
// writable registers, to be changed only while the parser is idle.
// ----------------------------------------------------------------------------
module sensor_frame_parser_top import sfp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  // input words
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  // result words
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_heart_word,
  output logic [31:0]        out_breath_word,
  output logic [31:0]        out_distance_word,
  output logic [7:0]         out_flag_byte
);

  sfp_cfg_t cfg;
  frame_t   frame;

  sfp_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  sfp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .frame     (frame)
  );

  assign out_heart_word    = frame.heart_word;
  assign out_breath_word   = frame.breath_word;
  assign out_distance_word = frame.distance_word;
  assign out_flag_byte     = frame.flag_byte;

endmodule

// File: hdl/sfp_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame parser register file
// APB-style configuration port holding start marker and command code.
// ----------------------------------------------------------------------------
module sfp_regs import sfp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  output sfp_cfg_t           cfg
);

  logic       wr_en;
  logic [0:0] reg_idx;
  logic [7:0] start_marker_r;
  logic [7:0] command_code_r;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[2];

  // Register writes on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= START_MARKER_RST;
      command_code_r <= COMMAND_CODE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_START_MARKER: start_marker_r <= cfg_pwdata[7:0];
        REG_COMMAND_CODE: command_code_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_START_MARKER: cfg_prdata = {24'd0, start_marker_r};
      REG_COMMAND_CODE: cfg_prdata = {24'd0, command_code_r};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.start_marker = start_marker_r;
  assign cfg.command_code = command_code_r;

endmodule

// File: hdl/sfp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame parser core
// Phase register, payload store and running XOR, updated once per word,
// with a result register on the output side.
// ----------------------------------------------------------------------------
module sfp_core import sfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  sfp_cfg_t   cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output frame_t     frame
);

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [7:0]       store_r [PAYLOAD_BYTES];
  logic             out_valid_r, out_valid_nxt;
  frame_t           frame_r;
  logic             in_fire;
  logic             emit;
  logic             store_we;
  frame_t           frame_nxt;

  // Only the check word can produce a result, so stall only there
  assign in_ready = !(phase_r == PH_CHECK && out_valid_r && !out_ready);
  assign in_fire  = in_valid && in_ready;

  // Next-state logic for one accepted word
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    xor_nxt   = xor_r;
    emit      = 1'b0;
    store_we  = 1'b0;
    if (in_fire) begin
      unique case (phase_r)
        PH_LEN: begin
          if (in_byte == FRAME_LEN_BYTE) begin
            xor_nxt   = xor_r ^ in_byte;
            phase_nxt = PH_CMD;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_CMD: begin
          if (in_byte == cfg.command_code) begin
            xor_nxt   = xor_r ^ in_byte;
            count_nxt = '0;
            phase_nxt = PH_DATA;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_DATA: begin
          store_we  = (count_r < CNT_W'(PAYLOAD_BYTES));
          xor_nxt   = xor_r ^ in_byte;
          count_nxt = count_r + 1'b1;
          if (count_nxt >= CNT_W'(PAYLOAD_BYTES)) begin
            phase_nxt = PH_CHECK;
          end
        end
        PH_CHECK: begin
          emit      = (in_byte == xor_r);
          count_nxt = '0;
          phase_nxt = PH_HUNT;
        end
        default: begin
          if (in_byte == cfg.start_marker) begin
            xor_nxt   = '0;
            count_nxt = '0;
            phase_nxt = PH_LEN;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
      endcase
    end
  end

  // Output handshake: hold until taken, load on a good check
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Big-endian packing of the payload store
  always_comb begin
    frame_nxt.heart_word    = {store_r[0], store_r[1], store_r[2], store_r[3]};
    frame_nxt.breath_word   = {store_r[4], store_r[5], store_r[6], store_r[7]};
    frame_nxt.distance_word = {store_r[8], store_r[9], store_r[10], store_r[11]};
    frame_nxt.flag_byte     = store_r[12];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      count_r     <= '0;
      xor_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      xor_r       <= xor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload store and result register
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[count_r[IDX_W-1:0]] <= in_byte;
    end
    if (emit) begin
      frame_r <= frame_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign frame     = frame_r;

endmodule
